[design/depth_pixel_colorizer_assert.svh]
// assertion helpers for the depth pixel colorizer
`ifndef DEPTH_PIXEL_COLORIZER_ASSERT_SVH
`define DEPTH_PIXEL_COLORIZER_ASSERT_SVH

`ifndef ASSERT_OFF
`define DPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dpc assertion failed");
`define DPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dpc assertion failed");
`else
`define DPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[design/dpc_pkg.sv]
package dpc_pkg;

  localparam int PIX_W      = 14;
  localparam int CSCL_W     = 29;
  localparam int GSCL_W     = 24;
  localparam int PROD_W     = PIX_W + CSCL_W;
  localparam int FRAC_W     = 16;
  localparam int CH_W       = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 29;

  localparam logic [PIX_W-1:0] CODE_LOW_AMP   = 14'd16001;
  localparam logic [PIX_W-1:0] CODE_SATURATED = 14'd16002;
  localparam logic [PIX_W-1:0] CODE_OVERFLOW  = 14'd16003;

  localparam logic [CFG_IDX_W-1:0] REG_GRAY_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_START = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_STOP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_SCALE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GRAY_SCALE  = 3'd4;

  localparam logic [PIX_W-1:0]  RST_RANGE_STOP  = 14'd16000;
  localparam logic [CSCL_W-1:0] RST_COLOR_SCALE = 29'd24576;
  localparam logic [GSCL_W-1:0] RST_GRAY_SCALE  = 24'd1044;

  typedef struct packed {
    logic              gray_mode;
    logic [PIX_W-1:0]  range_start;
    logic [PIX_W-1:0]  range_stop;
    logic [CSCL_W-1:0] color_scale;
    logic [GSCL_W-1:0] gray_scale;
  } cfg_t;

  // pixel class decided at the front of the pipe
  typedef enum logic [2:0] {
    CLS_SAT,
    CLS_OVF,
    CLS_BLACK,
    CLS_WHITE,
    CLS_ZERO,
    CLS_MAP,
    CLS_GRAY
  } cls_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_RISE,
    KIND_FLAT,
    KIND_FALL
  } kind_t;

endpackage

[design/depth_pixel_colorizer.sv]
// a pixel accepted at a clock edge passes the decode, product, index, two color
//   and output registers before its rgb beat shows on out_valid; stalls hold it
// throughput: one pixel per clock; an output stall freezes the whole pipe
// reset (rst_n low, synchronous): all stage valids clear, registers return
//   to jet mode, range 0..16000, color scale 24576, gray scale 1044
`include "depth_pixel_colorizer_assert.svh"

module depth_pixel_colorizer #(
  parameter int COLOR_STEPS = 6000
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [dpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dpc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [dpc_pkg::PIX_W-1:0]      in_pixel_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [dpc_pkg::CH_W-1:0]       out_red,
  output logic [dpc_pkg::CH_W-1:0]       out_green,
  output logic [dpc_pkg::CH_W-1:0]       out_blue
);
  import dpc_pkg::*;

  localparam int IDX_W = $clog2(COLOR_STEPS);

  cfg_t             cfg_r;
  logic             advance;
  logic [5:1]       vld_r;
  logic             out_valid_r;
  cls_t             cls1, cls3, cls4_r, cls5_r;
  logic [PIX_W-1:0] off1;
  logic [IDX_W-1:0] idx3;
  logic [CH_W-1:0]  lvl3, lvl4_r, lvl5_r;
  logic [CH_W-1:0]  map_r, map_g, map_b;
  logic [CH_W-1:0]  red_nxt, green_nxt, blue_nxt;
  logic [CH_W-1:0]  red_r, green_r, blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gray_mode   <= 1'b0;
      cfg_r.range_start <= '0;
      cfg_r.range_stop  <= RST_RANGE_STOP;
      cfg_r.color_scale <= RST_COLOR_SCALE;
      cfg_r.gray_scale  <= RST_GRAY_SCALE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRAY_MODE:   cfg_r.gray_mode   <= cfg_wdata[0];
        REG_RANGE_START: cfg_r.range_start <= cfg_wdata[PIX_W-1:0];
        REG_RANGE_STOP:  cfg_r.range_stop  <= cfg_wdata[PIX_W-1:0];
        REG_COLOR_SCALE: cfg_r.color_scale <= cfg_wdata[CSCL_W-1:0];
        REG_GRAY_SCALE:  cfg_r.gray_scale  <= cfg_wdata[GSCL_W-1:0];
        default: ;
      endcase
    end
  end

  // whole pipe moves unless a finished beat is held at the output
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      vld_r       <= {vld_r[4:1], in_valid};
      out_valid_r <= vld_r[5];
    end
  end

  dpc_decode u_decode (
    .clk   (clk),
    .en    (advance),
    .pixel (in_pixel_value),
    .cfg   (cfg_r),
    .cls   (cls1),
    .off   (off1)
  );

  dpc_scale #(.STEPS(COLOR_STEPS)) u_scale (
    .clk     (clk),
    .en      (advance),
    .off     (off1),
    .cls_in  (cls1),
    .cfg     (cfg_r),
    .idx     (idx3),
    .lvl     (lvl3),
    .cls_out (cls3)
  );

  dpc_chan #(.STEPS(COLOR_STEPS), .S(3), .WD(4)) u_chan_red (
    .clk   (clk),
    .en    (advance),
    .idx   (idx3),
    .value (map_r)
  );

  dpc_chan #(.STEPS(COLOR_STEPS), .S(1), .WD(3)) u_chan_green (
    .clk   (clk),
    .en    (advance),
    .idx   (idx3),
    .value (map_g)
  );

  dpc_chan #(.STEPS(COLOR_STEPS), .S(-1), .WD(2)) u_chan_blue (
    .clk   (clk),
    .en    (advance),
    .idx   (idx3),
    .value (map_b)
  );

  // class and grey level ride alongside the two color stages
  always_ff @(posedge clk) begin
    if (advance) begin
      cls4_r <= cls3;
      lvl4_r <= lvl3;
      cls5_r <= cls4_r;
      lvl5_r <= lvl4_r;
    end
  end

  always_comb begin
    case (cls5_r) inside
      CLS_SAT: begin
        red_nxt = 8'd255; green_nxt = 8'd0; blue_nxt = 8'd128;
      end
      CLS_OVF: begin
        red_nxt = 8'd169; green_nxt = 8'd14; blue_nxt = 8'd255;
      end
      CLS_WHITE: begin
        red_nxt = 8'd255; green_nxt = 8'd255; blue_nxt = 8'd255;
      end
      CLS_GRAY: begin
        red_nxt = lvl5_r; green_nxt = lvl5_r; blue_nxt = lvl5_r;
      end
      CLS_ZERO, CLS_MAP: begin
        red_nxt = map_r; green_nxt = map_g; blue_nxt = map_b;
      end
      default: begin
        red_nxt = '0; green_nxt = '0; blue_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

  `DPC_ASSERT_IMP(a_idx_in_map, clk, rst_n, vld_r[3], idx3 <= IDX_W'(COLOR_STEPS - 1))
  `DPC_ASSERT_NXT(a_sat_color, clk, rst_n, vld_r[5] && advance && cls5_r == CLS_SAT,
    out_valid && out_red == 8'd255 && out_green == 8'd0 && out_blue == 8'd128)
  `DPC_ASSERT_NXT(a_zero_entry, clk, rst_n, vld_r[5] && advance && cls5_r == CLS_ZERO,
    out_valid && out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd127)

endmodule

[design/dpc_decode.sv]
module dpc_decode (
  input  logic                 clk,
  input  logic                 en,
  input  logic [dpc_pkg::PIX_W-1:0] pixel,
  input  dpc_pkg::cfg_t        cfg,
  output dpc_pkg::cls_t        cls,
  output logic [dpc_pkg::PIX_W-1:0] off
);
  import dpc_pkg::*;

  cls_t             cls_r, cls_nxt;
  logic [PIX_W-1:0] off_r;
  logic             below, above;

  assign below = pixel < cfg.range_start;
  // off > stop - start is the same test as pixel > stop
  assign above = pixel > cfg.range_stop;

  always_comb begin
    if (pixel == CODE_SATURATED) begin
      cls_nxt = CLS_SAT;
    end else if (!cfg.gray_mode) begin
      if (pixel == CODE_OVERFLOW) begin
        cls_nxt = CLS_OVF;
      end else if (pixel == CODE_LOW_AMP) begin
        cls_nxt = CLS_BLACK;
      end else if (pixel == '0) begin
        cls_nxt = CLS_ZERO;
      end else if (below || above) begin
        cls_nxt = CLS_BLACK;
      end else begin
        cls_nxt = CLS_MAP;
      end
    end else begin
      if (above) begin
        cls_nxt = CLS_WHITE;
      end else if (below) begin
        cls_nxt = CLS_BLACK;
      end else begin
        cls_nxt = CLS_GRAY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cls_r <= cls_nxt;
      off_r <= pixel - cfg.range_start;
    end
  end

  assign cls = cls_r;
  assign off = off_r;

endmodule

[design/dpc_scale.sv]
module dpc_scale #(
  parameter int STEPS = 6000
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [dpc_pkg::PIX_W-1:0] off,
  input  dpc_pkg::cls_t             cls_in,
  input  dpc_pkg::cfg_t             cfg,
  output logic [$clog2(STEPS)-1:0]  idx,
  output logic [dpc_pkg::CH_W-1:0]  lvl,
  output dpc_pkg::cls_t             cls_out
);
  import dpc_pkg::*;

  localparam int IDX_W = $clog2(STEPS);
  localparam int RAW_W = $clog2(STEPS + 1);
  localparam int CW    = RAW_W + FRAC_W;
  localparam logic [PROD_W-1:0] TOP_Q = PROD_W'(STEPS) << FRAC_W;
  localparam logic [RAW_W-1:0]  LAST_RAW = RAW_W'(STEPS - 1);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(STEPS - 1);

  logic [CSCL_W-1:0] scl;
  logic [PROD_W-1:0] prod2_r;
  cls_t              cls2_r, cls3_r;
  logic [CW-1:0]     diff;
  logic [RAW_W-1:0]  raw;
  logic [IDX_W-1:0]  idx3_r, idx_nxt;
  logic [CH_W-1:0]   lvl3_r, lvl_nxt;

  assign scl = cfg.gray_mode ? {{(CSCL_W-GSCL_W){1'b0}}, cfg.gray_scale} : cfg.color_scale;

  always_ff @(posedge clk) begin
    if (en) begin
      prod2_r <= {{CSCL_W{1'b0}}, off} * {{PIX_W{1'b0}}, scl};
      cls2_r  <= cls_in;
    end
  end

  // index counts down from the top of the map
  assign diff = TOP_Q[CW-1:0] - prod2_r[CW-1:0];
  assign raw  = diff[CW-1:FRAC_W];

  always_comb begin
    if (cls2_r == CLS_ZERO || prod2_r > TOP_Q) begin
      idx_nxt = '0;
    end else if (raw > LAST_RAW) begin
      idx_nxt = LAST_IDX;
    end else begin
      idx_nxt = raw[IDX_W-1:0];
    end
  end

  assign lvl_nxt = (|prod2_r[PROD_W-1:FRAC_W+CH_W]) ? {CH_W{1'b1}}
                                                   : prod2_r[FRAC_W+CH_W-1:FRAC_W];

  always_ff @(posedge clk) begin
    if (en) begin
      idx3_r <= idx_nxt;
      lvl3_r <= lvl_nxt;
      cls3_r <= cls2_r;
    end
  end

  assign idx     = idx3_r;
  assign lvl     = lvl3_r;
  assign cls_out = cls3_r;

endmodule

[design/dpc_chan.sv]
module dpc_chan #(
  parameter int STEPS = 6000,
  parameter int S     = 3,
  parameter int WD    = 4
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [$clog2(STEPS)-1:0] idx,
  output logic [dpc_pkg::CH_W-1:0] value
);
  import dpc_pkg::*;

  localparam int IDX_W = $clog2(STEPS);
  localparam int EW    = IDX_W + 5;
  localparam int DW    = IDX_W + 2;
  localparam int XW    = IDX_W + 10;
  localparam int RW    = IDX_W + 2;
  localparam int DNW   = IDX_W + 3;

  localparam logic signed [EW-1:0] RISE_LO = EW'(S * STEPS);
  localparam logic signed [EW-1:0] RISE_HI = EW'((S + 2) * STEPS);
  localparam logic signed [EW-1:0] FLAT_HI = EW'((S + 4) * STEPS);
  localparam logic signed [EW-1:0] FALL_HI = EW'((S + 4 + WD) * STEPS);
  localparam logic [DNW-1:0] DEN_R  = DNW'(2 * STEPS);
  localparam logic [DNW-1:0] DEN_F  = DNW'(WD * STEPS);
  localparam logic [RW-1:0]  RCP_R  = RW'((1 << XW) / (2 * STEPS));
  localparam logic [RW-1:0]  RCP_F  = RW'((1 << XW) / (WD * STEPS));
  localparam logic [XW-1:0]  CEIL_F = XW'(WD * STEPS - 1);
  localparam logic [CH_W-1:0] FULL  = {CH_W{1'b1}};

  logic signed [EW-1:0] es, d_rise, d_fall;
  logic [DW-1:0]        d;
  logic [XW-1:0]        x255;
  kind_t                kind_nxt, kind_a_r, kind_b_r;
  logic [XW-1:0]        x_nxt, x_a_r, x_b_r;
  logic [RW-1:0]        rcp;
  logic [XW+RW-1:0]     prod_q;
  logic [CH_W-1:0]      qe_b_r, q;
  logic [DNW-1:0]       den;
  logic [CH_W+DNW-1:0]  qd;
  logic [XW-1:0]        rem;

  // position in eighths of the map, times the step count
  assign es     = $signed({2'b00, idx, 3'b000});
  assign d_rise = es - RISE_LO;
  assign d_fall = es - FLAT_HI;

  always_comb begin
    kind_nxt = KIND_NONE;
    d        = d_rise[DW-1:0];
    if (es >= RISE_LO && es < RISE_HI) begin
      kind_nxt = KIND_RISE;
    end else if (es >= RISE_HI && es < FLAT_HI) begin
      kind_nxt = KIND_FLAT;
    end else if (es >= FLAT_HI && es < FALL_HI) begin
      kind_nxt = KIND_FALL;
      d        = d_fall[DW-1:0];
    end
    x255  = ({{(XW-DW){1'b0}}, d} << 8) - {{(XW-DW){1'b0}}, d};
    x_nxt = (kind_nxt == KIND_FALL) ? x255 + CEIL_F : x255;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind_a_r <= kind_nxt;
      x_a_r    <= x_nxt;
    end
  end

  // reciprocal estimate, low by at most one
  assign rcp    = (kind_a_r == KIND_FALL) ? RCP_F : RCP_R;
  assign prod_q = {{RW{1'b0}}, x_a_r} * {{XW{1'b0}}, rcp};

  always_ff @(posedge clk) begin
    if (en) begin
      kind_b_r <= kind_a_r;
      x_b_r    <= x_a_r;
      qe_b_r   <= prod_q[XW+CH_W-1:XW];
    end
  end

  assign den = (kind_b_r == KIND_FALL) ? DEN_F : DEN_R;
  assign qd  = {{DNW{1'b0}}, qe_b_r} * {{CH_W{1'b0}}, den};
  assign rem = x_b_r - qd[XW-1:0];
  assign q   = qe_b_r + CH_W'(rem >= {{(XW-DNW){1'b0}}, den});

  always_comb begin
    case (kind_b_r)
      KIND_RISE: value = q;
      KIND_FLAT: value = FULL;
      KIND_FALL: value = FULL - q;
      default:   value = '0;
    endcase
  end

endmodule
